FILE: sv/upmx_pkg.sv
// Shared types, constants and the coefficient ROM of the stereo upmix FIR block.
`default_nettype none

package upmx_pkg;

    localparam int COEF_W     = 24;
    localparam int GAIN_W     = 16;
    localparam int GAIN_SHIFT = 13;
    localparam int COEF_SHIFT = 23;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = GAIN_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN    = 2'd2;

    localparam logic [1:0] MODE_STEREO = 2'd0;
    localparam logic [1:0] MODE_QUAD   = 2'd1;
    localparam logic [1:0] MODE_SIX    = 2'd2;

    localparam logic [2:0] COUNT_STEREO = 3'd2;
    localparam logic [2:0] COUNT_QUAD   = 3'd4;
    localparam logic [2:0] COUNT_SIX    = 3'd6;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd8192;

    // outer coefficient magnitudes, all applied negative, Q0.23
    localparam int SIDE_LEN = 63;
    localparam int SIDE_ROM [0:SIDE_LEN-1] = '{
        17408, 18257, 19133, 20035, 20964, 21920, 22903, 23913,
        24949, 26012, 27102, 28217, 29358, 30525, 31716, 32933,
        34173, 35436, 36722, 38030, 39359, 40708, 42076, 43463,
        44865, 46284, 47716, 49161, 50618, 52083, 53557, 55036,
        56519, 58005, 59490, 60972, 62449, 63919, 65379, 66826,
        68258, 69672, 71063, 72431, 73770, 75078, 76351, 77586,
        78779, 79926, 81024, 82067, 83053, 83977, 84834, 85621,
        86333, 86965, 87512, 87971, 88336, 88602, 88765
    };
    localparam int CENTER_COEF = 8299384;
    localparam int LAST_COEF   = -16585;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAIN_L,
        ST_GAIN_R,
        ST_GAIN_END,
        ST_WRITE,
        ST_MAC,
        ST_DRAIN,
        ST_FIR,
        ST_DONE
    } upmx_state_t;

    // what the product register holds, so the MAC knows where it goes
    typedef enum logic [2:0] {
        TAG_NONE,
        TAG_GAIN_L,
        TAG_GAIN_R,
        TAG_TAP_L,
        TAG_TAP_R
    } prod_tag_t;

    typedef struct packed {
        prod_tag_t tag;
        logic      clear;
    } mac_ctrl_t;

    // 128-entry ROM, symmetric about the center tap but for the last entry; zero beyond it
    function automatic logic signed [COEF_W-1:0] coef_at(input int unsigned k);
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (k < SIDE_LEN)
            c = COEF_W'(-SIDE_ROM[k]);
        else if (k == SIDE_LEN)
            c = COEF_W'(CENTER_COEF);
        else if (k <= 2 * SIDE_LEN)
            c = COEF_W'(-SIDE_ROM[2 * SIDE_LEN - k]);
        else if (k == 2 * SIDE_LEN + 1)
            c = COEF_W'(LAST_COEF);
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: sv/upmx_in_if.sv
// Input channel: one left/right sample pair per beat.
`default_nettype none

interface upmx_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

`default_nettype wire

FILE: sv/upmx_out_if.sv
// Output channel: six channel samples and the active channel count per beat.
`default_nettype none

interface upmx_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] ch0_sample;
    logic signed [SAMPLE_BITS-1:0] ch1_sample;
    logic signed [SAMPLE_BITS-1:0] ch2_sample;
    logic signed [SAMPLE_BITS-1:0] ch3_sample;
    logic signed [SAMPLE_BITS-1:0] ch4_sample;
    logic signed [SAMPLE_BITS-1:0] ch5_sample;
    logic [2:0]                    channel_count;

    modport source (
        output valid, output ch0_sample, output ch1_sample, output ch2_sample,
        output ch3_sample, output ch4_sample, output ch5_sample,
        output channel_count, input ready
    );
    modport sink (
        input valid, input ch0_sample, input ch1_sample, input ch2_sample,
        input ch3_sample, input ch4_sample, input ch5_sample,
        input channel_count, output ready
    );
endinterface

`default_nettype wire

FILE: sv/upmx_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module upmx_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/upmx_mac.sv
// Shared multiplier with product register, gain saturation and the two FIR accumulators.
`default_nettype none

module upmx_mac #(
    parameter int SAMPLE_BITS = 24,
    parameter int TAPS        = 128
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire upmx_pkg::mac_ctrl_t                    ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0]          op_a,
    input  wire logic signed [upmx_pkg::COEF_W-1:0]     op_b,
    output logic signed [SAMPLE_BITS-1:0]               gain_l,
    output logic signed [SAMPLE_BITS-1:0]               gain_r,
    output logic signed [SAMPLE_BITS-1:0]               fir_l,
    output logic signed [SAMPLE_BITS-1:0]               fir_r
);

    localparam int SB    = SAMPLE_BITS;
    localparam int PW    = SB + upmx_pkg::COEF_W;
    localparam int ACC_W = PW + $clog2(TAPS) + 1;

    localparam logic signed [PW-1:0] P_MAX = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [PW-1:0] P_MIN = ~P_MAX;
    localparam logic signed [ACC_W-1:0] A_MAX = {{(ACC_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] A_MIN = -A_MAX;

    logic signed [PW-1:0]    prod_reg;
    upmx_pkg::prod_tag_t     tag_reg;
    logic signed [ACC_W-1:0] acc_l_reg;
    logic signed [ACC_W-1:0] acc_r_reg;
    logic signed [SB-1:0]    gain_l_reg;
    logic signed [SB-1:0]    gain_r_reg;

    logic signed [PW-1:0]    gain_wide;
    logic signed [SB-1:0]    gain_sat;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] acc_l_shift;
    logic signed [ACC_W-1:0] acc_r_shift;

    // floor of product / 2^13, clamped to the full two's-complement range
    always_comb
    begin
        gain_wide = prod_reg >>> upmx_pkg::GAIN_SHIFT;
        if (gain_wide > P_MAX)
            gain_sat = P_MAX[SB-1:0];
        else if (gain_wide < P_MIN)
            gain_sat = P_MIN[SB-1:0];
        else
            gain_sat = gain_wide[SB-1:0];
    end

    assign prod_ext = {{(ACC_W-PW){prod_reg[PW-1]}}, prod_reg};

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg   <= upmx_pkg::TAG_NONE;
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end
        else
        begin
            tag_reg <= ctrl.tag;
            if (ctrl.clear)
            begin
                acc_l_reg <= '0;
                acc_r_reg <= '0;
            end
            else if (tag_reg == upmx_pkg::TAG_TAP_L)
            begin
                acc_l_reg <= acc_l_reg + prod_ext;
            end
            else if (tag_reg == upmx_pkg::TAG_TAP_R)
            begin
                acc_r_reg <= acc_r_reg + prod_ext;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_reg == upmx_pkg::TAG_GAIN_L)
        begin
            gain_l_reg <= gain_sat;
        end
        if (tag_reg == upmx_pkg::TAG_GAIN_R)
        begin
            gain_r_reg <= gain_sat;
        end
    end

    // FIR outputs: floor / 2^23, symmetric clamp
    always_comb
    begin
        acc_l_shift = acc_l_reg >>> upmx_pkg::COEF_SHIFT;
        acc_r_shift = acc_r_reg >>> upmx_pkg::COEF_SHIFT;
        if (acc_l_shift > A_MAX)
            fir_l = A_MAX[SB-1:0];
        else if (acc_l_shift < A_MIN)
            fir_l = A_MIN[SB-1:0];
        else
            fir_l = acc_l_shift[SB-1:0];
        if (acc_r_shift > A_MAX)
            fir_r = A_MAX[SB-1:0];
        else if (acc_r_shift < A_MIN)
            fir_r = A_MIN[SB-1:0];
        else
            fir_r = acc_r_shift[SB-1:0];
    end

    assign gain_l = gain_l_reg;
    assign gain_r = gain_r_reg;

endmodule

`default_nettype wire

FILE: sv/stereo_upmix_fir_unit.sv
// Top level of the stereo-to-surround upmixer with two FIR filters.
`default_nettype none

// Takes one left/right pair per beat, applies the Q3.13 input gain and, in the
// filter modes, runs both samples through TAPS-tap FIR filters whose history
// lives in one RAM (left and right side by side). A single multiplier does all
// the work: two gain products, then one left and one right product per tap.
// The input is not ready while an item is in flight; a finished result sits in
// the output register while the next item is accepted and processed, and that
// item waits in ST_DONE until the register is free. History reads as zero until
// written, tracked by a fill count, so no clearing pass is needed after reset.
// Configuration may only be written while the block is idle.
module stereo_upmix_fir_unit #(
    parameter int TAPS        = 128,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [upmx_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [upmx_pkg::CFG_DATA_W-1:0]    cfg_data,
    upmx_in_if.sink                                 stereo,
    upmx_out_if.source                              surround
);

    localparam int SB = SAMPLE_BITS;
    localparam int AW = $clog2(TAPS);
    localparam int KW = $clog2(TAPS + 1);
    localparam int CW = upmx_pkg::COEF_W;

    localparam logic signed [SB:0] S_MAX = {2'b00, {(SB-1){1'b1}}};
    localparam logic signed [SB:0] S_MIN = -S_MAX;

    upmx_pkg::upmx_state_t state_reg, state_next;

    logic                          filter_en_reg;
    logic [1:0]                    mode_reg;
    logic [upmx_pkg::GAIN_W-1:0]   gain_reg;

    logic signed [SB-1:0]          l_in_reg;
    logic signed [SB-1:0]          r_in_reg;
    logic [AW-1:0]                 widx_reg;
    logic [KW-1:0]                 fill_reg;
    logic [AW-1:0]                 rd_addr_reg;
    logic [KW-1:0]                 tap_reg;
    logic                          phase_reg;
    logic signed [CW-1:0]          coef_q_reg;
    logic                          valid_q_reg;
    logic signed [SB-1:0]          fir_l_reg;
    logic signed [SB-1:0]          fir_r_reg;

    logic                          out_valid_reg;
    logic signed [SB-1:0]          ch0_reg, ch1_reg, ch2_reg, ch3_reg, ch4_reg, ch5_reg;
    logic [2:0]                    count_reg;

    upmx_pkg::mac_ctrl_t           mac_ctrl;
    logic signed [SB-1:0]          op_a;
    logic signed [CW-1:0]          op_b;
    logic                          ram_we;
    logic [2*SB-1:0]               ram_rdata;
    logic signed [SB-1:0]          hist_l;
    logic signed [SB-1:0]          hist_r;
    logic signed [SB-1:0]          gain_l, gain_r, fir_l, fir_r;

    logic                          filt_on;
    logic                          six_ch;
    logic                          out_load;
    logic                          mac_last;
    logic signed [SB:0]            sum_lr, sum_fir;
    logic signed [SB-1:0]          sat_lr, sat_fir;

    assign filt_on  = filter_en_reg && (mode_reg != upmx_pkg::MODE_STEREO);
    assign six_ch   = filt_on && (mode_reg != upmx_pkg::MODE_QUAD);
    assign out_load = (state_reg == upmx_pkg::ST_DONE) && (!out_valid_reg || surround.ready);
    assign mac_last = (tap_reg == KW'(TAPS)) && !phase_reg;

    assign hist_l = valid_q_reg ? ram_rdata[2*SB-1:SB] : '0;
    assign hist_r = valid_q_reg ? ram_rdata[SB-1:0]    : '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            upmx_pkg::ST_IDLE:     if (stereo.valid) state_next = upmx_pkg::ST_GAIN_L;
            upmx_pkg::ST_GAIN_L:   state_next = upmx_pkg::ST_GAIN_R;
            upmx_pkg::ST_GAIN_R:   state_next = upmx_pkg::ST_GAIN_END;
            upmx_pkg::ST_GAIN_END: state_next = filt_on ? upmx_pkg::ST_WRITE : upmx_pkg::ST_DONE;
            upmx_pkg::ST_WRITE:    state_next = upmx_pkg::ST_MAC;
            upmx_pkg::ST_MAC:      if (mac_last) state_next = upmx_pkg::ST_DRAIN;
            upmx_pkg::ST_DRAIN:    state_next = upmx_pkg::ST_FIR;
            upmx_pkg::ST_FIR:      state_next = upmx_pkg::ST_DONE;
            upmx_pkg::ST_DONE:     if (out_load) state_next = upmx_pkg::ST_IDLE;
            default:               state_next = upmx_pkg::ST_IDLE;
        endcase
    end

    // multiplier operands and control
    always_comb
    begin
        mac_ctrl.tag   = upmx_pkg::TAG_NONE;
        mac_ctrl.clear = 1'b0;
        op_a           = '0;
        op_b           = '0;
        ram_we         = 1'b0;
        unique case (state_reg)
            upmx_pkg::ST_GAIN_L:
            begin
                mac_ctrl.tag = upmx_pkg::TAG_GAIN_L;
                op_a         = l_in_reg;
                op_b         = {{(CW-upmx_pkg::GAIN_W){1'b0}}, gain_reg};
            end
            upmx_pkg::ST_GAIN_R:
            begin
                mac_ctrl.tag = upmx_pkg::TAG_GAIN_R;
                op_a         = r_in_reg;
                op_b         = {{(CW-upmx_pkg::GAIN_W){1'b0}}, gain_reg};
            end
            upmx_pkg::ST_WRITE:
            begin
                mac_ctrl.clear = 1'b1;
                ram_we         = 1'b1;
            end
            upmx_pkg::ST_MAC:
            begin
                // read data of a tap is seen in its odd phase and the next even phase
                op_b = coef_q_reg;
                if (phase_reg)
                begin
                    mac_ctrl.tag = upmx_pkg::TAG_TAP_L;
                    op_a         = hist_l;
                end
                else if (tap_reg != '0)
                begin
                    mac_ctrl.tag = upmx_pkg::TAG_TAP_R;
                    op_a         = hist_r;
                end
            end
            default:
            begin
                mac_ctrl.tag = upmx_pkg::TAG_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= upmx_pkg::ST_IDLE;
            filter_en_reg <= 1'b0;
            mode_reg      <= upmx_pkg::MODE_STEREO;
            gain_reg      <= upmx_pkg::GAIN_UNITY;
            widx_reg      <= '0;
            fill_reg      <= '0;
            rd_addr_reg   <= '0;
            tap_reg       <= '0;
            phase_reg     <= 1'b0;
            valid_q_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    upmx_pkg::CFG_FILTER_ENABLE: filter_en_reg <= cfg_data[0];
                    upmx_pkg::CFG_OUTPUT_MODE:   mode_reg      <= cfg_data[1:0];
                    upmx_pkg::CFG_INPUT_GAIN:    gain_reg      <= cfg_data;
                    default:                     gain_reg      <= gain_reg;
                endcase
            end

            if (state_reg == upmx_pkg::ST_WRITE)
            begin
                widx_reg    <= (widx_reg == AW'(TAPS - 1)) ? '0 : widx_reg + 1'b1;
                fill_reg    <= (fill_reg == KW'(TAPS)) ? fill_reg : fill_reg + 1'b1;
                rd_addr_reg <= widx_reg;
                tap_reg     <= '0;
                phase_reg   <= 1'b0;
            end
            else if (state_reg == upmx_pkg::ST_MAC)
            begin
                phase_reg <= ~phase_reg;
                if (phase_reg)
                begin
                    tap_reg     <= tap_reg + 1'b1;
                    rd_addr_reg <= (rd_addr_reg == '0) ? AW'(TAPS - 1) : rd_addr_reg - 1'b1;
                end
            end

            // entries at or above the fill count were never written
            valid_q_reg <= KW'(rd_addr_reg) < fill_reg;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (surround.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_q_reg <= upmx_pkg::coef_at(int'(tap_reg));
        if (state_reg == upmx_pkg::ST_IDLE && stereo.valid)
        begin
            l_in_reg <= stereo.left_sample;
            r_in_reg <= stereo.right_sample;
        end
        if (state_reg == upmx_pkg::ST_FIR)
        begin
            fir_l_reg <= fir_l;
            fir_r_reg <= fir_r;
        end
    end

    // symmetric clamps on the two channel sums
    always_comb
    begin
        sum_lr  = {gain_l[SB-1], gain_l} + {gain_r[SB-1], gain_r};
        sum_fir = {fir_l_reg[SB-1], fir_l_reg} + {fir_r_reg[SB-1], fir_r_reg};
        if (sum_lr > S_MAX)
            sat_lr = S_MAX[SB-1:0];
        else if (sum_lr < S_MIN)
            sat_lr = S_MIN[SB-1:0];
        else
            sat_lr = sum_lr[SB-1:0];
        if (sum_fir > S_MAX)
            sat_fir = S_MAX[SB-1:0];
        else if (sum_fir < S_MIN)
            sat_fir = S_MIN[SB-1:0];
        else
            sat_fir = sum_fir[SB-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            ch1_reg <= gain_l;
            if (six_ch)
            begin
                ch0_reg   <= fir_l_reg;
                ch2_reg   <= sat_lr;
                ch3_reg   <= gain_r;
                ch4_reg   <= fir_r_reg;
                ch5_reg   <= sat_fir;
                count_reg <= upmx_pkg::COUNT_SIX;
            end
            else if (filt_on)
            begin
                ch0_reg   <= fir_l_reg;
                ch2_reg   <= gain_r;
                ch3_reg   <= fir_r_reg;
                ch4_reg   <= '0;
                ch5_reg   <= '0;
                count_reg <= upmx_pkg::COUNT_QUAD;
            end
            else
            begin
                ch0_reg   <= '0;
                ch2_reg   <= gain_r;
                ch3_reg   <= '0;
                ch4_reg   <= '0;
                ch5_reg   <= '0;
                count_reg <= upmx_pkg::COUNT_STEREO;
            end
        end
    end

    upmx_ram #(
        .WIDTH (2 * SB),
        .DEPTH (TAPS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (widx_reg),
        .wdata ({gain_l, gain_r}),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    upmx_mac #(
        .SAMPLE_BITS (SB),
        .TAPS        (TAPS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .op_a   (op_a),
        .op_b   (op_b),
        .gain_l (gain_l),
        .gain_r (gain_r),
        .fir_l  (fir_l),
        .fir_r  (fir_r)
    );

    assign stereo.ready           = (state_reg == upmx_pkg::ST_IDLE);
    assign surround.valid         = out_valid_reg;
    assign surround.ch0_sample    = ch0_reg;
    assign surround.ch1_sample    = ch1_reg;
    assign surround.ch2_sample    = ch2_reg;
    assign surround.ch3_sample    = ch3_reg;
    assign surround.ch4_sample    = ch4_reg;
    assign surround.ch5_sample    = ch5_reg;
    assign surround.channel_count = count_reg;

endmodule

`default_nettype wire

FILE: sv/upmx_checker.sv
// Port-level assertions for the upmix block, bound to the top level.
`default_nettype none

module upmx_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_ready,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic [SAMPLE_BITS-1:0] ch0,
    input wire logic [SAMPLE_BITS-1:0] ch3,
    input wire logic [SAMPLE_BITS-1:0] ch4,
    input wire logic [SAMPLE_BITS-1:0] ch5,
    input wire logic [2:0]             count
);

    // an item occupies the shared multiplier, so an accepted beat drops input ready
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after an accepted beat");

    a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count == upmx_pkg::COUNT_STEREO || count == upmx_pkg::COUNT_QUAD
                       || count == upmx_pkg::COUNT_SIX))
        else $error("illegal channel count");

    a_stereo_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && count == upmx_pkg::COUNT_STEREO
        |-> (ch0 == '0 && ch3 == '0 && ch4 == '0 && ch5 == '0))
        else $error("unused channel not zero in stereo beat");

    a_quad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && count == upmx_pkg::COUNT_QUAD |-> (ch4 == '0 && ch5 == '0))
        else $error("unused channel not zero in four-channel beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(count))
        else $error("output beat dropped while stalled");

endmodule

bind stereo_upmix_fir_unit upmx_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_upmx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (stereo.valid),
    .in_ready  (stereo.ready),
    .out_valid (surround.valid),
    .out_ready (surround.ready),
    .ch0       (surround.ch0_sample),
    .ch3       (surround.ch3_sample),
    .ch4       (surround.ch4_sample),
    .ch5       (surround.ch5_sample),
    .count     (surround.channel_count)
);

`default_nettype wire
